// ===== rtl/ljas_pkg.sv =====
// ljas_pkg: shared constants, cell data types and the cordic angle table
// for the leg joint angle solver; depends on nothing
`default_nettype none

package ljas_pkg;

	localparam int LJAS_COORD_WIDTH     = 16;
	localparam int LJAS_ANGLE_FRAC_BITS = 13;
	localparam int LINK_W               = 15;
	localparam logic [LINK_W-1:0] LINK_RESET = 15'd1600;

	localparam int SQRT_STEPS   = 32;
	localparam int DIV_STEPS    = 30;
	localparam int CORDIC_STEPS = 30;
	// normalize (two stages), cordic cells, clamp
	localparam int ATAN_LAT     = CORDIC_STEPS + 3;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;

	typedef enum logic [0:0] {
		CFG_UPPER_LINK = 1'b0,
		CFG_LOWER_LINK = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0] v;
		logic [35:0] r;
		logic [31:0] q;
	} sqrt_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] den;
		logic [29:0] q;
	} div_t;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [33:0] z;
	} cordic_t;

	// atan(2^-step) in Q30, truncated
	function automatic logic [33:0] atan_q30(input int unsigned step);
		logic [33:0] t;
		case (step)
			0:  t = 34'h3243F6A8;
			1:  t = 34'h1DAC6705;
			2:  t = 34'h0FADBAFC;
			3:  t = 34'h07F56EA6;
			4:  t = 34'h03FEAB76;
			5:  t = 34'h01FFD55B;
			6:  t = 34'h00FFFAAA;
			7:  t = 34'h007FFF55;
			8:  t = 34'h003FFFEA;
			9:  t = 34'h001FFFFD;
			10: t = 34'h000FFFFF;
			11: t = 34'h0007FFFF;
			12: t = 34'h0003FFFF;
			13: t = 34'h0001FFFF;
			14: t = 34'h0000FFFF;
			15: t = 34'h00007FFF;
			16: t = 34'h00003FFF;
			17: t = 34'h00001FFF;
			18: t = 34'h00000FFF;
			19: t = 34'h000007FF;
			20: t = 34'h000003FF;
			21: t = 34'h000001FF;
			22: t = 34'h000000FF;
			23: t = 34'h0000007F;
			24: t = 34'h0000003F;
			25: t = 34'h0000001F;
			26: t = 34'h0000000F;
			27: t = 34'h00000007;
			28: t = 34'h00000003;
			29: t = 34'h00000001;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ljas_in_if.sv =====
// ljas_in_if: valid/ready channel carrying one foot target word
// depends on ljas_pkg
`default_nettype none

interface ljas_in_if import ljas_pkg::*; #(
	parameter int COORD_WIDTH = LJAS_COORD_WIDTH
) ();
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] target_x;
	logic [COORD_WIDTH-1:0] target_y;
	logic [COORD_WIDTH-1:0] target_z;

	modport source(output valid, output target_x, output target_y, output target_z,
		input ready);
	modport sink(input valid, input target_x, input target_y, input target_z,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/ljas_out_if.sv =====
// ljas_out_if: valid/ready channel carrying one joint angle word
// depends on ljas_pkg
`default_nettype none

interface ljas_out_if import ljas_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = LJAS_ANGLE_FRAC_BITS
) ();
	localparam int AW = ANGLE_FRAC_BITS + 2;

	logic                 valid;
	logic                 ready;
	logic signed [AW-1:0] shoulder_angle;
	logic [AW-1:0]        hip_angle;
	logic [AW-1:0]        knee_angle;
	logic                 unreachable;

	modport source(output valid, output shoulder_angle, output hip_angle,
		output knee_angle, output unreachable, input ready);
	modport sink(input valid, input shoulder_angle, input hip_angle,
		input knee_angle, input unreachable, output ready);
endinterface

`default_nettype wire

// ===== rtl/ljas_sqrt_cell.sv =====
// ljas_sqrt_cell: one digit of a restoring integer square root
// depends on ljas_pkg
`default_nettype none

module ljas_sqrt_cell import ljas_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  sqrt_t d,
	output sqrt_t q
);
	logic [35:0] rr;
	logic [35:0] t;

	assign rr = {d.r[33:0], d.v[63:62]};
	assign t  = {2'b00, d.q, 2'b01};

	always_ff @(posedge clk) begin
		if (en) begin
			q.v <= {d.v[61:0], 2'b00};
			if (rr >= t) begin
				q.r <= rr - t;
				q.q <= {d.q[30:0], 1'b1};
			end else begin
				q.r <= rr;
				q.q <= {d.q[30:0], 1'b0};
			end
		end
	end
endmodule

`default_nettype wire

// ===== rtl/ljas_div_cell.sv =====
// ljas_div_cell: one quotient bit of a restoring fraction divide
// depends on ljas_pkg
`default_nettype none

module ljas_div_cell import ljas_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t d,
	output div_t q
);
	logic [63:0] r2;

	assign r2 = {d.rem[62:0], 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			q.den <= d.den;
			if (r2 >= d.den) begin
				q.rem <= r2 - d.den;
				q.q   <= {d.q[28:0], 1'b1};
			end else begin
				q.rem <= r2;
				q.q   <= {d.q[28:0], 1'b0};
			end
		end
	end
endmodule

`default_nettype wire

// ===== rtl/ljas_cordic_cell.sv =====
// ljas_cordic_cell: one vectoring rotation of a cordic chain
// depends on ljas_pkg (angle table)
`default_nettype none

module ljas_cordic_cell import ljas_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d,
	output cordic_t q
);
	localparam logic signed [33:0] ANG = atan_q30(STEP);

	logic signed [63:0] dx;
	logic signed [63:0] dy;

	assign dx = d.y >>> STEP;
	assign dy = d.x >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (d.y > 0) begin
				q.x <= d.x + dx;
				q.y <= d.y - dy;
				q.z <= d.z + ANG;
			end else begin
				q.x <= d.x - dx;
				q.y <= d.y + dy;
				q.z <= d.z - ANG;
			end
		end
	end
endmodule

`default_nettype wire

// ===== rtl/ljas_atan.sv =====
// ljas_atan: atan2 of two non-negative operands in Q30, clamped to [0, pi/2]
// depends on ljas_pkg and ljas_cordic_cell
`default_nettype none

module ljas_atan import ljas_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] ym,
	input  logic [31:0] xm,
	output logic [30:0] angle
);
	typedef struct packed {
		logic yz;
		logic xz;
	} zflag_t;

	logic [31:0] ym_s1, xm_s1;
	logic [4:0]  msb_s1;
	zflag_t      zf_s1;
	logic [31:0] mx;
	logic [4:0]  msb;
	logic [5:0]  sh;
	cordic_t     init_s2;
	zflag_t      zf_s2;
	cordic_t     cc [0:CORDIC_STEPS];
	zflag_t      zf_q [0:CORDIC_STEPS-1];
	logic signed [33:0] zr;

	// leading one of the larger operand
	assign mx = ym | xm;
	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (mx[i]) msb = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ym_s1  <= ym;
			xm_s1  <= xm;
			msb_s1 <= msb;
			zf_s1  <= '{yz: (ym == '0), xz: (xm == '0)};
		end
	end

	// larger operand lands in [2^59, 2^60)
	assign sh = 6'd59 - {1'b0, msb_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			init_s2.x <= signed'(64'(xm_s1) << sh);
			init_s2.y <= signed'(64'(ym_s1) << sh);
			init_s2.z <= '0;
			zf_s2     <= zf_s1;
		end
	end

	assign cc[0] = init_s2;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
		ljas_cordic_cell #(.STEP(k)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (cc[k]),
			.q   (cc[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zf_q[0] <= zf_s2;
			for (int k = 1; k < CORDIC_STEPS; k++) zf_q[k] <= zf_q[k-1];
		end
	end

	assign zr = cc[CORDIC_STEPS].z;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zf_q[CORDIC_STEPS-1].yz)                angle <= '0;
			else if (zf_q[CORDIC_STEPS-1].xz)           angle <= HALF_PI_Q30;
			else if (zr < 0)                            angle <= '0;
			else if (zr > signed'(34'(HALF_PI_Q30)))    angle <= HALF_PI_Q30;
			else                                        angle <= zr[30:0];
		end
	end
endmodule

`default_nettype wire

// ===== rtl/leg_joint_angle_solver.sv =====
// leg_joint_angle_solver: shoulder, hip and knee angles from a foot target
// one target word in and one result word out per cycle while the result word is taken
// the whole pipeline advances together; it holds while a finished word waits
// depth is set by the two 32-cell square root chains, the 30-cell divider and cordic
// reset clears the valid chain and loads both link lengths with 1600
`default_nettype none

module leg_joint_angle_solver import ljas_pkg::*; #(
	parameter int COORD_WIDTH     = LJAS_COORD_WIDTH,
	parameter int ANGLE_FRAC_BITS = LJAS_ANGLE_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	ljas_in_if.sink           target,
	ljas_out_if.source        result,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_idx,
	input  logic [LINK_W-1:0] cfg_data
);
	localparam int CW = COORD_WIDTH;
	localparam int G  = 32 - COORD_WIDTH;        // guard bits of the leg length
	localparam int AW = ANGLE_FRAC_BITS + 2;
	localparam int RS = 30 - ANGLE_FRAC_BITS;
	localparam logic [32:0] RND = 33'(1) << (29 - ANGLE_FRAC_BITS);

	// stage numbers along the main pipeline
	localparam int ST_SQ_IN  = 5;
	localparam int ST_SQ_OUT = ST_SQ_IN + SQRT_STEPS;
	localparam int ST_D1     = ST_SQ_OUT + 2;
	localparam int ST_DV_OUT = ST_D1 + DIV_STEPS;
	localparam int ST_C1     = ST_DV_OUT + 2;
	localparam int ST_S2_OUT = ST_C1 + SQRT_STEPS;
	localparam int ST_AT_OUT = ST_S2_OUT + ATAN_LAT;
	localparam int LAT       = ST_AT_OUT + 1;
	localparam int ST_SH     = 2 + ATAN_LAT + 1;  // shoulder finish stage
	localparam int SH_N      = LAT - ST_SH + 1;

	typedef struct packed {
		logic        hneg;
		logic [63:0] hmag;
		logic        kneg;
		logic [63:0] kmag;
		logic [30:0] kden;
	} law_t;

	typedef struct packed {
		logic hneg;
		logic hone;
		logic hflag;
		logic kneg;
		logic kone;
		logic kflag;
	} ratio_t;

	typedef struct packed {
		logic hneg;
		logic hflag;
		logic kneg;
		logic kflag;
	} sgn_t;

	typedef struct packed {
		sgn_t        f;
		logic [30:0] hc;
		logic [30:0] kc;
	} cos_t;

	typedef struct packed {
		logic xz;
		logic zz;
		logic neg;
	} shf_t;

	// ---------------------------------------------------------------- config
	logic [LINK_W-1:0] upper_q, lower_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= LINK_RESET;
			lower_q <= LINK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_UPPER_LINK: upper_q <= cfg_data;
				CFG_LOWER_LINK: lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	// one enable for every stage; a word waiting at the output holds the pipe
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en           = !vld_q[LAT-1] || result.ready;
	assign target.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], target.valid};
	end

	// ---------------------------------------------------------------- front end
	logic [CW-1:0]       x_s1, y_s1, z_s1;
	logic [CW-1:0]       ax_s2, ay_s2, az_s2;
	shf_t                shf_s2;
	logic [2*LINK_W-1:0] uu_s2, ww_s2, uw_s2;
	logic [2*CW-1:0]     sqx_s3, sqy_s3, sqz_s3;
	logic [2*LINK_W-1:0] uu_s3, ww_s3, uw_s3;
	logic [63:0]         s_s4;
	logic [2*LINK_W-1:0] uu_s4, ww_s4, uw_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= target.target_x;
			y_s1 <= target.target_y;
			z_s1 <= target.target_z;
		end
	end

	// magnitudes, shoulder sign rule, link products
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2      <= x_s1[CW-1] ? ~x_s1 + 1'b1 : x_s1;
			ay_s2      <= y_s1[CW-1] ? ~y_s1 + 1'b1 : y_s1;
			az_s2      <= z_s1[CW-1] ? ~z_s1 + 1'b1 : z_s1;
			shf_s2.xz  <= (x_s1 == '0);
			shf_s2.zz  <= (z_s1 == '0);
			// straight up or down when x is zero, else quadrant of z against x
			shf_s2.neg <= (x_s1 == '0) ? z_s1[CW-1]
				: ((z_s1 != '0) && (z_s1[CW-1] != x_s1[CW-1]));
			uu_s2      <= upper_q * upper_q;
			ww_s2      <= lower_q * lower_q;
			uw_s2      <= upper_q * lower_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3 <= ax_s2 * ax_s2;
			sqy_s3 <= ay_s2 * ay_s2;
			sqz_s3 <= az_s2 * az_s2;
			uu_s3  <= uu_s2;
			ww_s3  <= ww_s2;
			uw_s3  <= uw_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4  <= 64'(sqx_s3) + 64'(sqy_s3) + 64'(sqz_s3);
			uu_s4 <= uu_s3;
			ww_s4 <= ww_s3;
			uw_s4 <= uw_s3;
		end
	end

	// law of cosines numerators, knee denominator
	logic [63:0] ha, hb, hdiff, ka, kdiff;
	logic        hneg_c, kneg_c;
	law_t        law_s5;
	logic [63:0] v_s5;

	always_comb begin
		ha     = s_s4 + 64'(uu_s4);
		hb     = 64'(ww_s4);
		hneg_c = hb > ha;
		hdiff  = hneg_c ? hb - ha : ha - hb;
		ka     = 64'(uu_s4) + 64'(ww_s4);
		kneg_c = s_s4 > ka;
		kdiff  = kneg_c ? s_s4 - ka : ka - s_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			law_s5.hneg <= hneg_c;
			law_s5.hmag <= hdiff << G;
			law_s5.kneg <= kneg_c;
			law_s5.kmag <= kdiff;
			law_s5.kden <= {uw_s4, 1'b0};
			v_s5        <= s_s4 << (2 * G);
		end
	end

	// ---------------------------------------------------------------- leg length root
	sqrt_t lc [0:SQRT_STEPS];
	law_t  law_q [0:SQRT_STEPS-1];

	assign lc[0] = '{v: v_s5, r: '0, q: '0};

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_len
		ljas_sqrt_cell u_cell (.clk(clk), .en(en), .d(lc[k]), .q(lc[k+1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			law_q[0] <= law_s5;
			for (int k = 1; k < SQRT_STEPS; k++) law_q[k] <= law_q[k-1];
		end
	end

	// ---------------------------------------------------------------- hip denominator
	logic [LINK_W+31:0] hprod;
	logic [63:0]        hden_s38;
	law_t               law_s38;

	assign hprod = upper_q * lc[SQRT_STEPS].q;

	always_ff @(posedge clk) begin
		if (en) begin
			hden_s38 <= 64'({hprod, 1'b0});
			law_s38  <= law_q[SQRT_STEPS-1];
		end
	end

	// ---------------------------------------------------------------- ratio special cases
	// zero denominator or argument past one clamps to one and flags
	logic   hflag_c, hone_c, kflag_c, kone_c;
	logic [63:0] kden64;
	div_t   dh_s39, dk_s39;
	ratio_t rt_s39;

	always_comb begin
		kden64  = 64'(law_s38.kden);
		hflag_c = (hden_s38 == '0) || (law_s38.hmag > hden_s38);
		hone_c  = hflag_c || (law_s38.hmag == hden_s38);
		kflag_c = (kden64 == '0) || (law_s38.kmag > kden64);
		kone_c  = kflag_c || (law_s38.kmag == kden64);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dh_s39 <= '{rem: hone_c ? '0 : law_s38.hmag, den: hden_s38, q: '0};
			dk_s39 <= '{rem: kone_c ? '0 : law_s38.kmag, den: kden64, q: '0};
			rt_s39 <= '{hneg: law_s38.hneg, hone: hone_c, hflag: hflag_c,
				kneg: law_s38.kneg, kone: kone_c, kflag: kflag_c};
		end
	end

	// ---------------------------------------------------------------- cosine dividers
	div_t   dh [0:DIV_STEPS];
	div_t   dk [0:DIV_STEPS];
	ratio_t rt_q [0:DIV_STEPS-1];

	assign dh[0] = dh_s39;
	assign dk[0] = dk_s39;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		ljas_div_cell u_hip  (.clk(clk), .en(en), .d(dh[k]), .q(dh[k+1]));
		ljas_div_cell u_knee (.clk(clk), .en(en), .d(dk[k]), .q(dk[k+1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_q[0] <= rt_s39;
			for (int k = 1; k < DIV_STEPS; k++) rt_q[k] <= rt_q[k-1];
		end
	end

	// ---------------------------------------------------------------- sine squared
	ratio_t      rt_e;
	logic [30:0] hc_c, kc_c;
	logic [30:0] hc_s70, kc_s70, hc_s71, kc_s71;
	logic [61:0] hcsq_s70, kcsq_s70;
	sgn_t        sg_s70, sg_s71;
	logic [63:0] hv_s71, kv_s71;

	assign rt_e = rt_q[DIV_STEPS-1];
	assign hc_c = rt_e.hone ? ONE_Q30 : {1'b0, dh[DIV_STEPS].q};
	assign kc_c = rt_e.kone ? ONE_Q30 : {1'b0, dk[DIV_STEPS].q};

	always_ff @(posedge clk) begin
		if (en) begin
			hc_s70   <= hc_c;
			kc_s70   <= kc_c;
			hcsq_s70 <= hc_c * hc_c;
			kcsq_s70 <= kc_c * kc_c;
			sg_s70   <= '{hneg: rt_e.hneg, hflag: rt_e.hflag,
				kneg: rt_e.kneg, kflag: rt_e.kflag};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hv_s71 <= ONE_Q60 - 64'(hcsq_s70);
			kv_s71 <= ONE_Q60 - 64'(kcsq_s70);
			hc_s71 <= hc_s70;
			kc_s71 <= kc_s70;
			sg_s71 <= sg_s70;
		end
	end

	// ---------------------------------------------------------------- sine roots
	sqrt_t hs [0:SQRT_STEPS];
	sqrt_t ks [0:SQRT_STEPS];
	cos_t  cs_q [0:SQRT_STEPS-1];

	assign hs[0] = '{v: hv_s71, r: '0, q: '0};
	assign ks[0] = '{v: kv_s71, r: '0, q: '0};

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sin
		ljas_sqrt_cell u_hip  (.clk(clk), .en(en), .d(hs[k]), .q(hs[k+1]));
		ljas_sqrt_cell u_knee (.clk(clk), .en(en), .d(ks[k]), .q(ks[k+1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_q[0] <= '{f: sg_s71, hc: hc_s71, kc: kc_s71};
			for (int k = 1; k < SQRT_STEPS; k++) cs_q[k] <= cs_q[k-1];
		end
	end

	// ---------------------------------------------------------------- acos angles
	logic [30:0] hang, kang;
	sgn_t        sg_q [0:ATAN_LAT-1];

	ljas_atan u_hip_atan (
		.clk   (clk),
		.en    (en),
		.ym    (hs[SQRT_STEPS].q),
		.xm    (32'(cs_q[SQRT_STEPS-1].hc)),
		.angle (hang)
	);

	ljas_atan u_knee_atan (
		.clk   (clk),
		.en    (en),
		.ym    (ks[SQRT_STEPS].q),
		.xm    (32'(cs_q[SQRT_STEPS-1].kc)),
		.angle (kang)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sg_q[0] <= cs_q[SQRT_STEPS-1].f;
			for (int k = 1; k < ATAN_LAT; k++) sg_q[k] <= sg_q[k-1];
		end
	end

	function automatic logic [AW-1:0] round_q30(input logic [31:0] v);
		logic [32:0] t;
		t = 33'(v) + RND;
		return t[RS +: AW];
	endfunction

	// negative cosine mirrors the angle about pi/2
	logic [31:0]   hres, kres;
	logic [AW-1:0] hip_q, knee_q;
	logic          unr_q;
	sgn_t          sg_e;

	assign sg_e = sg_q[ATAN_LAT-1];
	assign hres = sg_e.hneg ? PI_Q30 - 32'(hang) : 32'(hang);
	assign kres = sg_e.kneg ? PI_Q30 - 32'(kang) : 32'(kang);

	always_ff @(posedge clk) begin
		if (en) begin
			hip_q  <= round_q30(hres);
			knee_q <= round_q30(kres);
			unr_q  <= sg_e.hflag || sg_e.kflag;
		end
	end

	// ---------------------------------------------------------------- shoulder
	// runs early off the magnitudes, then waits in a delay line
	logic [30:0]   sang, smag;
	logic [AW-1:0] srnd;
	shf_t          shf_q [0:ATAN_LAT-1];
	shf_t          shf_e;
	logic [AW-1:0] sh_q [0:SH_N-1];

	ljas_atan u_sh_atan (
		.clk   (clk),
		.en    (en),
		.ym    (32'(az_s2)),
		.xm    (32'(ax_s2)),
		.angle (sang)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			shf_q[0] <= shf_s2;
			for (int k = 1; k < ATAN_LAT; k++) shf_q[k] <= shf_q[k-1];
		end
	end

	assign shf_e = shf_q[ATAN_LAT-1];
	// x zero: plus or minus pi/2, or zero when z is zero too
	assign smag  = shf_e.xz ? (shf_e.zz ? '0 : HALF_PI_Q30) : sang;
	assign srnd  = round_q30(32'(smag));

	always_ff @(posedge clk) begin
		if (en) begin
			sh_q[0] <= shf_e.neg ? ~srnd + 1'b1 : srnd;
			for (int k = 1; k < SH_N; k++) sh_q[k] <= sh_q[k-1];
		end
	end

	// ---------------------------------------------------------------- result word
	assign result.valid          = vld_q[LAT-1];
	assign result.shoulder_angle = signed'(sh_q[SH_N-1]);
	assign result.hip_angle      = hip_q;
	assign result.knee_angle     = knee_q;
	assign result.unreachable    = unr_q;
endmodule

`default_nettype wire

// ===== sim/ljas_angle_checker.sv =====
// ljas_angle_checker: watches the target and result channels, predicts joint angles
// from the foot target and link lengths, compares field by field; depends on ljas_pkg
module ljas_angle_checker import ljas_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ljas_in_if                target,
	ljas_out_if               result,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_idx,
	input  logic [LINK_W-1:0] cfg_data,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW = LJAS_ANGLE_FRAC_BITS + 2;
	localparam int GUARD = 32 - LJAS_COORD_WIDTH;

	typedef struct packed {
		logic [AW-1:0] shoulder;
		logic [AW-1:0] hip;
		logic [AW-1:0] knee;
		logic          unreach;
	} angles_t;

	logic [LINK_W-1:0] upper_len, lower_len;
	angles_t angle_queue[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring cordic, both operands non-negative, q30 angle in [0, pi/2]
	function automatic logic [63:0] vector_angle(input logic [63:0] ym, input logic [63:0] xm);
		logic signed [63:0] x, y, z, dx, dy;
		if (ym == 0) return 0;
		if (xm == 0) return 64'(HALF_PI_Q30);
		while (ym >= (64'd1 << 60) || xm >= (64'd1 << 60)) begin
			ym >>= 1;
			xm >>= 1;
		end
		while (ym < (64'd1 << 59) && xm < (64'd1 << 59)) begin
			ym <<= 1;
			xm <<= 1;
		end
		x = xm;
		y = ym;
		z = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += 64'(atan_q30(i));
			end else begin
				x -= dx; y += dy; z -= 64'(atan_q30(i));
			end
		end
		if (z < 0) z = 0;
		if (z > $signed(64'(HALF_PI_Q30))) z = 64'(HALF_PI_Q30);
		return z;
	endfunction

	function automatic logic [63:0] round_q30(input logic [63:0] q);
		return (q + (64'd1 << (29 - LJAS_ANGLE_FRAC_BITS))) >> (30 - LJAS_ANGLE_FRAC_BITS);
	endfunction

	// |num|/den in q30 with clamp to one
	function automatic logic [63:0] cos_q30(input logic [63:0] mag, input logic [63:0] den,
		inout logic flag);
		logic [63:0] rem, q;
		if (den == 0 || mag > den) begin
			flag = 1;
			return 64'(ONE_Q30);
		end
		if (mag == den) return 64'(ONE_Q30);
		rem = mag;
		q = 0;
		for (int i = 0; i < 30; i++) begin
			rem <<= 1;
			q <<= 1;
			if (rem >= den) begin
				rem -= den;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] acos_q(input logic neg, input logic [63:0] c);
		logic [63:0] a;
		a = vector_angle(int_sqrt(ONE_Q60 - c * c), c);
		return round_q30(neg ? 64'(PI_Q30) - a : a);
	endfunction

	function automatic angles_t joint_angles(input logic signed [15:0] x,
		input logic signed [15:0] y, input logic signed [15:0] z);
		angles_t r;
		logic [63:0] ax, ay, az, s, u, w, a, b, mag, den, sh;
		logic neg, flag;
		ax = x < 0 ? 64'(-int'(x)) : 64'(x);
		ay = y < 0 ? 64'(-int'(y)) : 64'(y);
		az = z < 0 ? 64'(-int'(z)) : 64'(z);
		u = upper_len;
		w = lower_len;
		s = ax * ax + ay * ay + az * az;
		flag = 0;
		if (x == 0) begin
			sh = (z == 0) ? 0 : round_q30(64'(HALF_PI_Q30));
			neg = z < 0;
		end else begin
			sh = round_q30(vector_angle(az, ax));
			neg = (z != 0) && ((z < 0) != (x < 0));
		end
		r.shoulder = AW'(neg ? -sh : sh);
		a = s + u * u;
		b = w * w;
		neg = b > a;
		mag = (neg ? b - a : a - b) << GUARD;
		den = 2 * u * int_sqrt(s << (2 * GUARD));
		r.hip = AW'(acos_q(neg, cos_q30(mag, den, flag)));
		a = u * u + w * w;
		neg = s > a;
		mag = neg ? s - a : a - s;
		r.knee = AW'(acos_q(neg, cos_q30(mag, 2 * u * w, flag)));
		r.unreach = flag;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = angle_queue.size();

	always @(posedge clk or negedge arst_n) begin
		angles_t want;
		if (!arst_n) begin
			upper_len <= LINK_RESET;
			lower_len <= LINK_RESET;
			errors = 0;
			angle_queue.delete();
		end else begin
			// predict with the lengths in force before this edge's write
			if (target.valid && target.ready)
				angle_queue.push_back(joint_angles(target.target_x, target.target_y,
					target.target_z));
			if (result.valid && result.ready) begin
				if (angle_queue.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					want = angle_queue.pop_front();
					if (result.shoulder_angle !== want.shoulder)
						report_mismatch("shoulder", result.shoulder_angle, $signed(want.shoulder));
					if (result.hip_angle !== want.hip)
						report_mismatch("hip", result.hip_angle, want.hip);
					if (result.knee_angle !== want.knee)
						report_mismatch("knee", result.knee_angle, want.knee);
					if (result.unreachable !== want.unreach)
						report_mismatch("unreachable", result.unreachable, want.unreach);
				end
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_UPPER_LINK) upper_len <= cfg_data;
				else upper_len <= upper_len;
				if (cfg_idx == CFG_LOWER_LINK) lower_len <= cfg_data;
			end
		end
	end
endmodule

// ===== sim/tb_leg_joint_angle_solver.sv =====
// tb_leg_joint_angle_solver: stimulus and verdict for the leg joint angle solver
// depends on ljas_pkg, ljas_in_if, ljas_out_if, ljas_angle_checker
module tb_leg_joint_angle_solver;
	timeunit 1ns;
	timeprecision 1ps;
	import ljas_pkg::*;

	localparam int PIPE_LAT = 137;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [0:0] cfg_idx = CFG_UPPER_LINK;
	logic [LINK_W-1:0] cfg_data = '0;
	int errors, pending;
	int cycles = 0;
	int send_idle = 0, recv_idle = 0;

	ljas_in_if target();
	ljas_out_if result();

	leg_joint_angle_solver dut (
		.clk(clk), .arst_n(arst_n), .target(target), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	ljas_angle_checker checker_i (
		.clk(clk), .arst_n(arst_n), .target(target), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_leg_joint_angle_solver NOT OK");
			$finish;
		end
	end

	// receiver stalls at the current rate
	initial result.ready = 0;
	always @(posedge clk)
		result.ready <= ($urandom_range(99) >= recv_idle);

	initial begin
		target.valid = 0;
		target.target_x = 0;
		target.target_y = 0;
		target.target_z = 0;
	end

	// one target word; gaps drawn from the sender idle rate
	task automatic send_target(input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z);
		while ($urandom_range(99) < send_idle) begin
			target.valid <= 0;
			@(posedge clk);
		end
		target.valid <= 1;
		target.target_x <= x;
		target.target_y <= y;
		target.target_z <= z;
		@(posedge clk);
		while (!target.ready) @(posedge clk);
	endtask

	// let everything drain, valid low, then some pipeline slack
	task automatic drain();
		target.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic write_link(input cfg_idx_t idx, input logic [LINK_W-1:0] len);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// coordinate: mostly within leg reach, sometimes full range, zero or an extreme
	function automatic logic [15:0] rand_coord(input int reach);
		int k;
		k = $urandom_range(9);
		if (k < 6) return 16'($signed($urandom_range(2 * reach)) - reach);
		if (k < 8) return 16'($urandom);
		if (k == 8) return 16'(0);
		return $urandom_range(1) ? 16'h8000 : 16'h7fff;
	endfunction

	task automatic random_burst(input int count, input int reach);
		for (int i = 0; i < count; i++)
			send_target(rand_coord(reach), rand_coord(reach), rand_coord(reach));
	endtask

	initial begin
		logic [15:0] edge_vals[7];
		edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0c80, 16'hf380};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_idle = 25;
		recv_idle = 65;

		// directed: shoulder on the axes, zero length, exact reach, far targets
		send_target(0, 0, 0);
		send_target(0, 100, 500);
		send_target(0, 100, -500);
		send_target(16'd3200, 0, 0);
		send_target(16'hf380, 0, 16'h0c80);
		send_target(16'h0c80, 16'h0100, 16'hf380);
		send_target(16'h7fff, 16'h7fff, 16'h7fff);
		send_target(16'h8000, 16'h8000, 16'h8000);
		send_target(16'h8000, 0, 16'h7fff);
		send_target(16'h0001, 0, 16'h0001);
		send_target(16'hffff, 16'hffff, 16'h0001);
		for (int i = 0; i < 7; i++)
			send_target(edge_vals[i], edge_vals[(i + 3) % 7], edge_vals[(i + 5) % 7]);
		// hold off until every result is back
		drain();

		// smallest links: nearly everything out of reach
		write_link(CFG_UPPER_LINK, 1);
		write_link(CFG_LOWER_LINK, 1);
		send_target(1, 0, 0);
		send_target(0, 0, 0);
		send_target(2, 0, 0);
		random_burst(150, 3);
		drain();

		// unequal links
		write_link(CFG_UPPER_LINK, 15'd900);
		write_link(CFG_LOWER_LINK, 15'd2500);
		random_burst(450, 3500);
		drain();

		send_idle = 65;
		recv_idle = 25;
		// largest links
		write_link(CFG_UPPER_LINK, 15'h7fff);
		write_link(CFG_LOWER_LINK, 15'h7fff);
		random_burst(350, 32767);
		drain();

		write_link(CFG_UPPER_LINK, 15'h5555);
		write_link(CFG_LOWER_LINK, 15'h2aaa);
		random_burst(300, 32767);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_link(CFG_UPPER_LINK, 15'd1600);
		write_link(CFG_LOWER_LINK, 15'd1600);
		random_burst(580, 3200);
		drain();

		if (errors == 0)
			$display("tb_leg_joint_angle_solver OK");
		else
			$display("tb_leg_joint_angle_solver NOT OK");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/ljas_pkg.sv
rtl/ljas_in_if.sv
rtl/ljas_out_if.sv
rtl/ljas_sqrt_cell.sv
rtl/ljas_div_cell.sv
rtl/ljas_cordic_cell.sv
rtl/ljas_atan.sv
rtl/leg_joint_angle_solver.sv
sim/ljas_angle_checker.sv
sim/tb_leg_joint_angle_solver.sv
